// ----- sv/ffpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types, codes and sizes shared by the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int MAX_BLOCKS  = 64;
	localparam int IDX_W       = $clog2(MAX_BLOCKS);
	localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
	localparam int ALIGN_SHIFT = 8;
	localparam int UNIT_W      = 32;
	localparam int ADDR_W      = 48;
	localparam int BYTES_W     = 40;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;

	localparam logic [1:0] CFG_POOL_ENABLE  = 2'd0;
	localparam logic [1:0] CFG_POOL_UNITS   = 2'd1;
	localparam logic [1:0] CFG_BASE_ADDRESS = 2'd2;

	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_NOT_ENABLE = 3'd1;
	localparam logic [2:0] STAT_NO_MEMORY  = 3'd2;
	localparam logic [2:0] STAT_TABLE_FULL = 3'd3;
	localparam logic [2:0] STAT_BAD_ADDR   = 3'd4;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;
	typedef enum logic [1:0] {CMD_HOLD, CMD_ROT, CMD_INIT, CMD_EDIT} cmd_op_t;
	typedef enum logic [1:0] {SH_NONE, SH_L1, SH_L2, SH_INS} shift_t;

	typedef struct packed {
		logic [UNIT_W-1:0] offset;
		logic [UNIT_W-1:0] units;
		logic              is_free;
	} entry_t;

	typedef struct packed {
		cmd_op_t          op;
		logic             wen;
		logic [IDX_W-1:0] widx;
		entry_t           wval;
		shift_t           shift;
		logic [IDX_W-1:0] ridx;
		entry_t           ival;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [BYTES_W-1:0] request_bytes;
		logic [ADDR_W-1:0]  release_address;
	} in_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  grant_address;
		logic [2:0]         status;
		logic [BYTES_W-1:0] allocated_bytes;
		logic [BYTES_W-1:0] free_bytes;
	} out_word_t;

endpackage
`default_nettype wire

// ----- sv/first_fit_pool_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_top
// Allocate or free rotates the whole cell row once past the head in S_SCAN
// and then settles in S_APPLY; query, disabled and free of zero go from
// S_IDLE straight to S_APPLY. One word at a time, taken only in S_IDLE.
// Reset: one free zero-unit block in a zero-unit pool, pool disabled, base zero.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [47:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire ffpa_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ffpa_pkg::out_word_t      out_word
);

	localparam int N  = ffpa_pkg::MAX_BLOCKS;
	localparam int IW = ffpa_pkg::IDX_W;
	localparam int CW = ffpa_pkg::CNT_W;
	localparam int UW = ffpa_pkg::UNIT_W;

	ffpa_pkg::state_t   state_q, state_d;
	ffpa_pkg::in_word_t in_q;
	ffpa_pkg::cmd_t     cmd;
	ffpa_pkg::entry_t   head;

	logic          enable_q;
	logic [UW-1:0] pool_q;
	logic [47:0]   base_q;
	logic [CW-1:0] count_q, count_d;
	logic [UW-1:0] alloc_q, alloc_d;
	logic [UW:0]   need_q, need_d;
	logic          skip_q;
	logic [IW-1:0] j_q, k_q;
	logic          found_q;
	logic [UW-1:0] koff_q, kunits_q, pu_q, nu_q, prv_units_q;
	logic          pf_q, nf_q, prv_free_q;
	logic          out_valid_q;
	logic [47:0]   grant_q, res_grant;
	logic [2:0]    status_q, res_status;

	logic          accept, out_free, apply, j_live, hit;
	logic [47:0]   head_addr;

	ffpa_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (head)
	);

	assign accept   = in_valid && state_q == ffpa_pkg::S_IDLE;
	assign out_free = !out_valid_q || !out_stall;
	assign apply    = state_q == ffpa_pkg::S_APPLY && out_free;
	assign j_live   = {1'b0, j_q} < count_q;
	assign head_addr = base_q + {8'd0, head.offset, 8'd0};

	always_comb begin
		need_d = {1'b0, in_word.request_bytes[39:8]} + (UW+1)'(|in_word.request_bytes[7:0]);
		if (need_d == '0) need_d = (UW+1)'(1);
	end

	always_comb begin
		if (in_q.operation == ffpa_pkg::OP_ALLOC)
			hit = j_live && head.is_free && {1'b0, head.units} >= need_q;
		else
			hit = j_live && !head.is_free && head_addr == in_q.release_address;
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.op     = ffpa_pkg::CMD_HOLD;
		cmd.shift  = ffpa_pkg::SH_NONE;
		count_d    = count_q;
		alloc_d    = alloc_q;
		res_grant  = '0;
		res_status = ffpa_pkg::STAT_OK;
		case (state_q)
			ffpa_pkg::S_IDLE: begin
				if (cfg_write && cfg_index == ffpa_pkg::CFG_POOL_UNITS) begin
					cmd.op   = ffpa_pkg::CMD_INIT;
					cmd.wval = '{offset: '0, units: cfg_data[UW-1:0], is_free: 1'b1};
					count_d  = CW'(1);
					alloc_d  = '0;
				end
				if (in_valid) begin
					if (!enable_q || in_word.operation[1] ||
					    (in_word.operation == ffpa_pkg::OP_FREE &&
					     in_word.release_address == '0))
						state_d = ffpa_pkg::S_APPLY;
					else
						state_d = ffpa_pkg::S_SCAN;
				end
			end
			ffpa_pkg::S_SCAN: begin
				cmd.op = ffpa_pkg::CMD_ROT;
				if (j_q == IW'(N - 1)) state_d = ffpa_pkg::S_APPLY;
			end
			ffpa_pkg::S_APPLY: begin
				if (skip_q) begin
					res_status = enable_q ? ffpa_pkg::STAT_OK : ffpa_pkg::STAT_NOT_ENABLE;
				end else if (in_q.operation == ffpa_pkg::OP_ALLOC) begin
					if (!found_q) begin
						res_status = ffpa_pkg::STAT_NO_MEMORY;
					end else if ({1'b0, kunits_q} > need_q && count_q >= CW'(N)) begin
						res_status = ffpa_pkg::STAT_TABLE_FULL;
					end else begin
						res_grant = base_q + {8'd0, koff_q, 8'd0};
						alloc_d   = alloc_q + need_q[UW-1:0];
						cmd.op    = ffpa_pkg::CMD_EDIT;
						cmd.wen   = 1'b1;
						cmd.widx  = k_q;
						cmd.wval  = '{offset: koff_q, units: need_q[UW-1:0], is_free: 1'b0};
						if ({1'b0, kunits_q} > need_q) begin
							cmd.shift = ffpa_pkg::SH_INS;
							cmd.ridx  = k_q + IW'(1);
							cmd.ival  = '{offset: koff_q + need_q[UW-1:0],
							              units: kunits_q - need_q[UW-1:0], is_free: 1'b1};
							count_d   = count_q + CW'(1);
						end
					end
				end else begin
					if (!found_q) begin
						res_status = ffpa_pkg::STAT_BAD_ADDR;
					end else begin
						alloc_d  = (alloc_q >= kunits_q) ? alloc_q - kunits_q : '0;
						cmd.op   = ffpa_pkg::CMD_EDIT;
						cmd.wen  = 1'b1;
						cmd.wval.is_free = 1'b1;
						if (pf_q) begin
							cmd.widx         = k_q - IW'(1);
							cmd.wval.units   = pu_q + kunits_q + (nf_q ? nu_q : '0);
							cmd.ridx         = k_q;
							cmd.shift        = nf_q ? ffpa_pkg::SH_L2 : ffpa_pkg::SH_L1;
							count_d          = count_q - (nf_q ? CW'(2) : CW'(1));
							cmd.wval.offset  = koff_q - pu_q;
						end else begin
							cmd.widx         = k_q;
							cmd.wval.offset  = koff_q;
							cmd.wval.units   = kunits_q + (nf_q ? nu_q : '0);
							cmd.ridx         = k_q + IW'(1);
							cmd.shift        = nf_q ? ffpa_pkg::SH_L1 : ffpa_pkg::SH_NONE;
							count_d          = count_q - (nf_q ? CW'(1) : CW'(0));
						end
					end
				end
				if (!out_free) begin
					cmd.op  = ffpa_pkg::CMD_HOLD;
					count_d = count_q;
					alloc_d = alloc_q;
				end else begin
					state_d = ffpa_pkg::S_IDLE;
				end
			end
			default: state_d = ffpa_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffpa_pkg::S_IDLE;
			enable_q    <= 1'b0;
			pool_q      <= '0;
			base_q      <= '0;
			count_q     <= CW'(1);
			alloc_q     <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			j_q         <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			alloc_q <= alloc_d;
			if (state_q == ffpa_pkg::S_IDLE && cfg_write) begin
				case (cfg_index)
					ffpa_pkg::CFG_POOL_ENABLE:  enable_q <= cfg_data[0];
					ffpa_pkg::CFG_POOL_UNITS:   pool_q   <= cfg_data[UW-1:0];
					ffpa_pkg::CFG_BASE_ADDRESS: base_q   <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				found_q <= 1'b0;
				j_q     <= '0;
			end
			if (state_q == ffpa_pkg::S_SCAN) begin
				j_q <= j_q + IW'(1);
				if (hit && !found_q) found_q <= 1'b1;
			end
			if (apply) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q   <= in_word;
			need_q <= need_d;
			skip_q <= !enable_q || in_word.operation[1] ||
			          (in_word.operation == ffpa_pkg::OP_FREE &&
			           in_word.release_address == '0);
			nf_q   <= 1'b0;
		end
		if (state_q == ffpa_pkg::S_SCAN) begin
			prv_free_q  <= head.is_free;
			prv_units_q <= head.units;
			if (hit && !found_q) begin
				k_q      <= j_q;
				koff_q   <= head.offset;
				kunits_q <= head.units;
				pf_q     <= (j_q != '0) && prv_free_q;
				pu_q     <= prv_units_q;
				nf_q     <= 1'b0;
			end
			if (found_q && j_q == k_q + IW'(1) && j_live) begin
				nf_q <= head.is_free;
				nu_q <= head.units;
			end
		end
		if (apply) begin
			grant_q  <= res_grant;
			status_q <= res_status;
		end
	end

	assign in_stall  = state_q != ffpa_pkg::S_IDLE;
	assign out_valid = out_valid_q;
	assign out_word  = '{grant_address:   grant_q,
	                     status:          status_q,
	                     allocated_bytes: {alloc_q, 8'd0},
	                     free_bytes:      {pool_q - alloc_q, 8'd0}};

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CW'(N))
		else $error("block count out of range");
	a_alloc_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q <= pool_q)
		else $error("allocated units exceed pool");
	a_result_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ffpa_pkg::S_APPLY))
		else $error("result without apply");
	a_scan_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffpa_pkg::S_SCAN && j_q == IW'(N - 1)) |=> state_q == ffpa_pkg::S_APPLY)
		else $error("scan did not end after one rotation");
`endif

endmodule
`default_nettype wire

// ----- sv/ffpa_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_cell
// One table entry; loads from a neighbour, a broadcast value or holds.
// ----------------------------------------------------------------------------
module ffpa_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [ffpa_pkg::IDX_W-1:0] index,
	input  wire ffpa_pkg::cmd_t        cmd,
	input  wire ffpa_pkg::entry_t      rot_in,
	input  wire ffpa_pkg::entry_t      l1_in,
	input  wire ffpa_pkg::entry_t      l2_in,
	input  wire ffpa_pkg::entry_t      r1_in,
	output ffpa_pkg::entry_t           entry
);

	ffpa_pkg::entry_t entry_q;
	ffpa_pkg::entry_t entry_d;

	always_comb begin
		entry_d = entry_q;
		case (cmd.op)
			ffpa_pkg::CMD_HOLD: entry_d = entry_q;
			ffpa_pkg::CMD_ROT:  entry_d = rot_in;
			ffpa_pkg::CMD_INIT: entry_d = (index == '0) ? cmd.wval : '0;
			ffpa_pkg::CMD_EDIT: begin
				if (cmd.wen && index == cmd.widx) begin
					entry_d = cmd.wval;
				end else begin
					case (cmd.shift)
						ffpa_pkg::SH_L1: if (index >= cmd.ridx) entry_d = l1_in;
						ffpa_pkg::SH_L2: if (index >= cmd.ridx) entry_d = l2_in;
						ffpa_pkg::SH_INS: begin
							if (index > cmd.ridx) entry_d = r1_in;
							else if (index == cmd.ridx) entry_d = cmd.ival;
						end
						default: entry_d = entry_q;
					endcase
				end
			end
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) entry_q <= '{offset: '0, units: '0, is_free: (index == '0)};
		else entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// ----- sv/ffpa_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_chain
// Row of table cells; entry zero sits at the head and is seen by control.
// ----------------------------------------------------------------------------
module ffpa_chain (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ffpa_pkg::cmd_t   cmd,
	output ffpa_pkg::entry_t      head
);

	localparam int N = ffpa_pkg::MAX_BLOCKS;

	ffpa_pkg::entry_t ent [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		ffpa_pkg::entry_t l1;
		ffpa_pkg::entry_t l2;
		ffpa_pkg::entry_t r1;
		if (i + 1 < N) begin : g_l1
			assign l1 = ent[i+1];
		end else begin : g_l1z
			assign l1 = '0;
		end
		if (i + 2 < N) begin : g_l2
			assign l2 = ent[i+2];
		end else begin : g_l2z
			assign l2 = '0;
		end
		if (i > 0) begin : g_r1
			assign r1 = ent[i-1];
		end else begin : g_r1z
			assign r1 = '0;
		end
		ffpa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.index  (ffpa_pkg::IDX_W'(i)),
			.cmd    (cmd),
			.rot_in (ent[(i + 1) % N]),
			.l1_in  (l1),
			.l2_in  (l2),
			.r1_in  (r1),
			.entry  (ent[i])
		);
	end

	assign head = ent[0];

endmodule
`default_nettype wire

// ----- test/first_fit_pool_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_top_tb
// Drives allocate, free, query and spare-opcode words into the pool allocator under random
// idling on both channels. It predicts the block table and byte totals for
// each accepted word and checks every result word field by field, in order.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_top_tb;

	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 80;

	class pool_scoreboard;
		logic [31:0] blk_offset [ffpa_pkg::MAX_BLOCKS];
		logic [31:0] blk_units [ffpa_pkg::MAX_BLOCKS];
		bit blk_free [ffpa_pkg::MAX_BLOCKS];
		int blk_count;
		longint unsigned used_units;
		bit enabled;
		logic [31:0] pool_cap;
		logic [47:0] base;
		ffpa_pkg::out_word_t pending [$];
		int errors;

		function void clear_table();
			for (int i = 0; i < ffpa_pkg::MAX_BLOCKS; i++) begin
				blk_offset[i] = '0;
				blk_units[i] = '0;
				blk_free[i] = 0;
			end
			blk_units[0] = pool_cap;
			blk_free[0] = 1;
			blk_count = 1;
			used_units = 0;
		endfunction

		function new();
			enabled = 0;
			pool_cap = '0;
			base = '0;
			errors = 0;
			clear_table();
		endfunction

		function void write_reg(logic [1:0] idx, logic [47:0] val);
			case (idx)
				ffpa_pkg::CFG_POOL_ENABLE: enabled = val[0];
				ffpa_pkg::CFG_POOL_UNITS: begin
					pool_cap = val[31:0];
					clear_table();
				end
				ffpa_pkg::CFG_BASE_ADDRESS: base = val;
				default: ;
			endcase
		endfunction

		function logic [47:0] block_addr(int k);
			logic [47:0] a;
			a = base + {8'd0, blk_offset[k], 8'd0};
			return a;
		endfunction

		function logic [47:0] pick_live();
			int live [$];
			for (int k = 0; k < blk_count; k++)
				if (!blk_free[k])
					live.push_back(k);
			if (live.size() == 0)
				return '0;
			return block_addr(live[$urandom_range(0, live.size() - 1)]);
		endfunction

		function void drop_entry(int k);
			for (int i = k; i + 1 < blk_count; i++) begin
				blk_offset[i] = blk_offset[i + 1];
				blk_units[i] = blk_units[i + 1];
				blk_free[i] = blk_free[i + 1];
			end
			blk_count--;
		endfunction

		function logic [2:0] take_block(logic [39:0] req, output logic [47:0] grant);
			longint unsigned need;
			int k;
			need = ({24'd0, req} + 64'd255) >> 8;
			if (need == 0)
				need = 1;
			grant = '0;
			for (k = 0; k < blk_count; k++)
				if (blk_free[k] && blk_units[k] >= need)
					break;
			if (k >= blk_count)
				return ffpa_pkg::STAT_NO_MEMORY;
			if (blk_units[k] > need) begin
				if (blk_count >= ffpa_pkg::MAX_BLOCKS)
					return ffpa_pkg::STAT_TABLE_FULL;
				for (int i = blk_count; i > k + 1; i--) begin
					blk_offset[i] = blk_offset[i - 1];
					blk_units[i] = blk_units[i - 1];
					blk_free[i] = blk_free[i - 1];
				end
				blk_offset[k + 1] = blk_offset[k] + need[31:0];
				blk_units[k + 1] = blk_units[k] - need[31:0];
				blk_free[k + 1] = 1;
				blk_count++;
				blk_units[k] = need[31:0];
			end
			blk_free[k] = 0;
			used_units += need;
			grant = block_addr(k);
			return ffpa_pkg::STAT_OK;
		endfunction

		function logic [2:0] release_block(logic [47:0] addr);
			int k;
			if (addr == '0)
				return ffpa_pkg::STAT_OK;
			for (k = 0; k < blk_count; k++)
				if (!blk_free[k] && block_addr(k) == addr)
					break;
			if (k >= blk_count)
				return ffpa_pkg::STAT_BAD_ADDR;
			blk_free[k] = 1;
			used_units = used_units >= blk_units[k] ? used_units - blk_units[k] : 0;
			if (k + 1 < blk_count && blk_free[k + 1]) begin
				blk_units[k] += blk_units[k + 1];
				drop_entry(k + 1);
			end
			if (k > 0 && blk_free[k - 1]) begin
				blk_units[k - 1] += blk_units[k];
				drop_entry(k);
			end
			return ffpa_pkg::STAT_OK;
		endfunction

		function void note(ffpa_pkg::in_word_t w);
			ffpa_pkg::out_word_t e;
			logic [47:0] grant;
			longint unsigned spare;
			grant = '0;
			if (!enabled)
				e.status = ffpa_pkg::STAT_NOT_ENABLE;
			else if (w.operation == ffpa_pkg::OP_ALLOC)
				e.status = take_block(w.request_bytes, grant);
			else if (w.operation == ffpa_pkg::OP_FREE)
				e.status = release_block(w.release_address);
			else
				e.status = ffpa_pkg::STAT_OK;
			spare = pool_cap >= used_units ? pool_cap - used_units : 0;
			e.grant_address = grant;
			e.allocated_bytes = used_units * 256;
			e.free_bytes = spare * 256;
			pending.push_back(e);
		endfunction

		task report(string what, logic [47:0] got, logic [47:0] want);
			$display("%0t: %s got %h want %h", $time, what, got, want);
			errors++;
		endtask

		task check(ffpa_pkg::out_word_t g);
			ffpa_pkg::out_word_t e;
			if (pending.size() == 0) begin
				report("unexpected word", g.status, 0);
				return;
			end
			e = pending.pop_front();
			if (g.grant_address !== e.grant_address)
				report("grant_address", g.grant_address, e.grant_address);
			if (g.status !== e.status)
				report("status", g.status, e.status);
			if (g.allocated_bytes !== e.allocated_bytes)
				report("allocated_bytes", g.allocated_bytes, e.allocated_bytes);
			if (g.free_bytes !== e.free_bytes)
				report("free_bytes", g.free_bytes, e.free_bytes);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [47:0] cfg_data;
	logic in_valid;
	logic in_stall;
	ffpa_pkg::in_word_t in_word;
	logic out_valid;
	logic out_stall;
	ffpa_pkg::out_word_t out_word;

	pool_scoreboard sb;
	bit quiet;
	int stall_left;
	int idle_cycles;

	first_fit_pool_allocator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (quiet) begin
			out_stall <= 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 10);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check(out_word);
		if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task write_reg(logic [1:0] idx, logic [47:0] val);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 0;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task wait_drained();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task send(ffpa_pkg::in_word_t w);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note(w);
		@(negedge clk);
	endtask

	task send_op(logic [1:0] op, logic [39:0] req, logic [47:0] addr);
		ffpa_pkg::in_word_t w;
		w.operation = op;
		w.request_bytes = req;
		w.release_address = addr;
		send(w);
	endtask

	function ffpa_pkg::in_word_t random_word();
		ffpa_pkg::in_word_t w;
		int r;
		w.operation = ffpa_pkg::OP_ALLOC;
		w.request_bytes = {$urandom, $urandom};
		w.release_address = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 50) begin
			if (r >= 3)
				w.request_bytes = $urandom_range(0, 1100);
		end else if (r < 85) begin
			w.operation = ffpa_pkg::OP_FREE;
			w.release_address = sb.pick_live();
		end else if (r < 92) begin
			w.operation = ffpa_pkg::OP_FREE;
			case ($urandom_range(0, 3))
				0: w.release_address = '0;
				1: w.release_address = sb.pick_live() + 48'd256;
				2: w.release_address = sb.block_addr($urandom_range(0, sb.blk_count - 1));
				default: ;
			endcase
		end else begin
			w.operation = $urandom_range(0, 1) ? OP_QUERY : OP_SPARE;
		end
		return w;
	endfunction

	initial begin
		logic [31:0] phase_units [8];
		phase_units = '{64, 1, 300, 20, 150, 2, 1000, 100};
		sb = new();
		quiet = 0;
		stall_left = 0;
		idle_cycles = 0;
		arst_n = 0;
		cfg_write = 0;
		cfg_index = ffpa_pkg::CFG_POOL_ENABLE;
		cfg_data = '0;
		in_valid = 0;
		in_word = '0;
		out_stall = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_op(ffpa_pkg::OP_ALLOC, 40'd256, '0);
		send_op(ffpa_pkg::OP_FREE, '0, 48'h1000);
		send_op(OP_QUERY, '0, '0);
		wait_drained();
		write_reg(ffpa_pkg::CFG_POOL_ENABLE, 48'd1);
		send_op(ffpa_pkg::OP_ALLOC, '0, '0);
		send_op(OP_SPARE, '1, '1);
		wait_drained();
		write_reg(ffpa_pkg::CFG_POOL_UNITS, 48'hFFFF_FFFF);
		write_reg(ffpa_pkg::CFG_BASE_ADDRESS, 48'hFFFF_FFFF_FF00);
		send_op(ffpa_pkg::OP_ALLOC, '1, '0);
		send_op(ffpa_pkg::OP_ALLOC, '0, '0);
		send_op(ffpa_pkg::OP_ALLOC, 40'h80_0000_0000, '0);
		send_op(ffpa_pkg::OP_FREE, '0, 48'hFFFF_FFFF_FF00);
		send_op(ffpa_pkg::OP_FREE, '0, '0);
		send_op(ffpa_pkg::OP_FREE, '0, '1);
		send_op(ffpa_pkg::OP_FREE, '0, sb.pick_live());
		wait_drained();
		write_reg(ffpa_pkg::CFG_POOL_UNITS, 48'd3);
		write_reg(ffpa_pkg::CFG_BASE_ADDRESS, 48'h1000);
		send_op(ffpa_pkg::OP_ALLOC, 40'd1, '0);
		send_op(ffpa_pkg::OP_ALLOC, 40'd256, '0);
		send_op(ffpa_pkg::OP_ALLOC, 40'd257, '0);
		send_op(ffpa_pkg::OP_ALLOC, 40'd200, '0);
		send_op(ffpa_pkg::OP_FREE, '0, 48'h1100);
		send_op(ffpa_pkg::OP_FREE, '0, 48'h1100);
		send_op(ffpa_pkg::OP_FREE, '0, 48'h1080);
		send_op(ffpa_pkg::OP_FREE, '0, 48'h1000);
		send_op(ffpa_pkg::OP_FREE, '0, 48'h1200);
		send_op(ffpa_pkg::OP_ALLOC, 40'd768, '0);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			if (p == 7)
				quiet = 1;
			write_reg(ffpa_pkg::CFG_POOL_ENABLE, p == 5 ? 48'd0 : 48'd1);
			write_reg(ffpa_pkg::CFG_BASE_ADDRESS,
			          p == 2 ? '1 : p == 4 ? '0 : {$urandom, $urandom});
			write_reg(ffpa_pkg::CFG_POOL_UNITS, {16'd0, phase_units[p]});
			for (int n = 0; n < 200; n++) begin
				if (p == 3 && n == 100)
					wait_drained();
				send(random_word());
			end
			wait_drained();
		end

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
